### rtl/pcee_pkg.sv
// Shared types, constants and helpers for the point cloud extreme extent block.
`timescale 1ns / 1ps

package pcee_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int ROOT_BITS      = COORD_BITS + 1;
    localparam int EXT_COUNT      = 6;
    localparam int EXT_IDX_BITS   = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // order: min x, max x, min y, max y, min z, max z
    typedef t_point [EXT_COUNT-1:0] t_ext_set;

    function automatic t_coord get_comp(input t_point p, input t_axis a);
        t_coord c;
        unique case (a)
            AXIS_X:  c = p.x;
            AXIS_Y:  c = p.y;
            AXIS_Z:  c = p.z;
            default: c = p.x;
        endcase
        return c;
    endfunction

    function automatic logic [EXT_IDX_BITS-1:0] min_idx(input t_axis a);
        return EXT_IDX_BITS'({a, 1'b0});
    endfunction

    function automatic logic [EXT_IDX_BITS-1:0] max_idx(input t_axis a);
        return EXT_IDX_BITS'({a, 1'b1});
    endfunction

endpackage

### rtl/pcee_pt_if.sv
// Point request channel: x, y, z coordinates and the last point marker.
`timescale 1ns / 1ps

interface pcee_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcee_pkg::COORD_BITS-1:0] x_coord;
    logic signed [pcee_pkg::COORD_BITS-1:0] y_coord;
    logic signed [pcee_pkg::COORD_BITS-1:0] z_coord;
    logic                                last_point;

    modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

### rtl/pcee_res_if.sv
// Result request channel: longest extent and its axis.
`timescale 1ns / 1ps

interface pcee_res_if;
    logic                               valid;
    logic                               ready;
    logic [pcee_pkg::ROOT_BITS-1:0]     longest_extent;
    logic [1:0]                         extent_axis;

    modport source (output valid, longest_extent, extent_axis, input ready);
    modport sink   (input valid, longest_extent, extent_axis, output ready);
endinterface

### rtl/pcee_front.sv
// Front end: accepts points and tracks the six extreme points of the cluster.
`timescale 1ns / 1ps

module pcee_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcee_pt_if.sink           i_pt,
    input  logic              i_q_full,
    output logic              o_q_push,
    output pcee_pkg::t_ext_set o_q_data
);

    pcee_pkg::t_ext_set r_ext;
    pcee_pkg::t_ext_set n_ext;
    logic               r_started;
    pcee_pkg::t_point   pt;
    logic               accept;

    assign pt.x   = i_pt.x_coord;
    assign pt.y   = i_pt.y_coord;
    assign pt.z   = i_pt.z_coord;
    assign i_pt.ready = !i_q_full;
    assign accept = i_pt.valid && !i_q_full;

    always_comb begin
        n_ext = r_ext;
        if (!r_started) begin
            for (int e = 0; e < pcee_pkg::EXT_COUNT; e++) begin
                n_ext[e] = pt;
            end
        end else begin
            for (int a = 0; a < 3; a++) begin
                if (pcee_pkg::get_comp(pt, pcee_pkg::t_axis'(2'(a))) <
                    pcee_pkg::get_comp(r_ext[pcee_pkg::min_idx(pcee_pkg::t_axis'(2'(a)))],
                                       pcee_pkg::t_axis'(2'(a)))) begin
                    n_ext[pcee_pkg::min_idx(pcee_pkg::t_axis'(2'(a)))] = pt;
                end
                if (pcee_pkg::get_comp(pt, pcee_pkg::t_axis'(2'(a))) >
                    pcee_pkg::get_comp(r_ext[pcee_pkg::max_idx(pcee_pkg::t_axis'(2'(a)))],
                                       pcee_pkg::t_axis'(2'(a)))) begin
                    n_ext[pcee_pkg::max_idx(pcee_pkg::t_axis'(2'(a)))] = pt;
                end
            end
        end
    end

    assign o_q_push = accept && i_pt.last_point;
    assign o_q_data = n_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (accept) begin
            r_started <= !i_pt.last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ext <= n_ext;
        end
    end

endmodule

### rtl/pcee_queue.sv
// Short queue of finished extreme point sets between front and back end.
`timescale 1ns / 1ps

module pcee_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pcee_pkg::t_ext_set i_data,
    output logic               o_full,
    output logic               o_valid,
    output pcee_pkg::t_ext_set o_data,
    input  logic               i_pop
);

    pcee_pkg::t_ext_set                  r_mem [pcee_pkg::QUEUE_DEPTH];
    logic [pcee_pkg::QUEUE_PTR_BITS-1:0] r_wr;
    logic [pcee_pkg::QUEUE_PTR_BITS-1:0] r_rd;
    logic [pcee_pkg::QUEUE_CNT_BITS-1:0] r_count;
    logic                                do_push;
    logic                                do_pop;

    assign o_full  = (r_count == pcee_pkg::QUEUE_CNT_BITS'(pcee_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/pcee_back.sv
// Back end: squared pair distances, axis selection and iterative square root.
`timescale 1ns / 1ps

module pcee_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pcee_pkg::t_ext_set i_q_data,
    output logic               o_q_pop,
    pcee_res_if.source         o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SQRT,
        S_DONE
    } t_state;

    t_state                          r_state;
    pcee_pkg::t_axis                 r_axis;
    pcee_pkg::t_axis                 r_comp;
    logic [pcee_pkg::SQ_BITS-1:0]    r_sq;
    logic [pcee_pkg::SUM_BITS-1:0]   r_acc;
    logic [pcee_pkg::SUM_BITS-1:0]   r_best;
    pcee_pkg::t_axis                 r_best_axis;
    logic [pcee_pkg::SUM_BITS-1:0]   r_rem;
    logic [pcee_pkg::SUM_BITS-1:0]   r_root;
    logic [pcee_pkg::SUM_BITS-1:0]   r_bit;
    logic                            r_out_valid;
    logic [pcee_pkg::ROOT_BITS-1:0]  r_out_extent;
    pcee_pkg::t_axis                 r_out_axis;

    pcee_pkg::t_coord                  c_max;
    pcee_pkg::t_coord                  c_min;
    logic signed [pcee_pkg::COORD_BITS:0] diff;
    logic [pcee_pkg::COORD_BITS:0]     diff_abs;
    logic [pcee_pkg::COORD_BITS-1:0]   mag;
    logic [pcee_pkg::SUM_BITS-1:0]     sum;
    logic                              take_best;
    logic [pcee_pkg::SUM_BITS-1:0]     n_best;
    logic [pcee_pkg::SUM_BITS:0]       trial;
    logic                              rem_ge;
    logic                              out_free;

    assign c_max    = pcee_pkg::get_comp(i_q_data[pcee_pkg::max_idx(r_axis)], r_comp);
    assign c_min    = pcee_pkg::get_comp(i_q_data[pcee_pkg::min_idx(r_axis)], r_comp);
    assign diff     = {c_max[pcee_pkg::COORD_BITS-1], c_max} -
                      {c_min[pcee_pkg::COORD_BITS-1], c_min};
    assign diff_abs = diff[pcee_pkg::COORD_BITS] ? 
                      (pcee_pkg::COORD_BITS+1)'(-diff) : diff;
    assign mag      = diff_abs[pcee_pkg::COORD_BITS-1:0];

    assign sum       = r_acc + pcee_pkg::SUM_BITS'(r_sq);
    assign take_best = (r_axis == pcee_pkg::AXIS_X) || (sum > r_best);
    assign n_best    = take_best ? sum : r_best;

    assign trial  = {1'b0, r_root} + {1'b0, r_bit};
    assign rem_ge = ({1'b0, r_rem} >= trial);

    assign out_free = !r_out_valid || o_res.ready;
    assign o_q_pop  = (r_state == S_ADD) && (r_comp == pcee_pkg::AXIS_Z) &&
                      (r_axis == pcee_pkg::AXIS_Z);

    assign o_res.valid          = r_out_valid;
    assign o_res.longest_extent = r_out_extent;
    assign o_res.extent_axis    = r_out_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_axis  <= pcee_pkg::AXIS_X;
                        r_comp  <= pcee_pkg::AXIS_X;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sq    <= mag * mag;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    unique case (r_comp)
                        pcee_pkg::AXIS_X: r_comp <= pcee_pkg::AXIS_Y;
                        pcee_pkg::AXIS_Y: r_comp <= pcee_pkg::AXIS_Z;
                        default:          r_comp <= pcee_pkg::AXIS_X;
                    endcase
                    if (r_comp == pcee_pkg::AXIS_Z) begin
                        r_acc  <= '0;
                        r_best <= n_best;
                        if (take_best) begin
                            r_best_axis <= r_axis;
                        end
                        unique case (r_axis)
                            pcee_pkg::AXIS_X: begin
                                r_axis  <= pcee_pkg::AXIS_Y;
                                r_state <= S_MUL;
                            end
                            pcee_pkg::AXIS_Y: begin
                                r_axis  <= pcee_pkg::AXIS_Z;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_rem   <= n_best;
                                r_root  <= '0;
                                r_bit   <= pcee_pkg::SUM_BITS'(1) << (pcee_pkg::SUM_BITS - 2);
                                r_state <= S_SQRT;
                            end
                        endcase
                    end else begin
                        r_acc   <= sum;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    if (rem_ge) begin
                        r_rem  <= r_rem - trial[pcee_pkg::SUM_BITS-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == pcee_pkg::SUM_BITS'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_extent <= r_root[pcee_pkg::ROOT_BITS-1:0];
                        r_out_axis   <= r_best_axis;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/point_cloud_extreme_extent.sv
// Throughput: one point per cycle while the queue is not full; per cluster the back end
// runs 9 multiply and 9 add steps for the three squared distances and 17 square root
// steps; a two-entry queue of extreme sets lets the front keep taking points meanwhile.
// Reset: synchronous, active low; clears the cluster, the queue and the result valid.
`timescale 1ns / 1ps

module point_cloud_extreme_extent (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pcee_pt_if.sink  i_pt,
    pcee_res_if.source o_res
);

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    pcee_pkg::t_ext_set q_wdata;
    pcee_pkg::t_ext_set q_rdata;

    pcee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pt     (i_pt),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    pcee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    pcee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

### rtl/pcee_checker.sv
// Port level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module pcee_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic [pcee_pkg::ROOT_BITS-1:0] i_res_extent,
    input logic [1:0]                     i_res_axis
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_no_early_result: assert property (@(posedge i_clk)
        $rose(i_rst_n) |=> !i_res_valid)
        else $error("result appeared too soon after reset");

    a_extent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_extent <= pcee_pkg::ROOT_BITS'(113509)))
        else $error("extent beyond largest possible value");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_extent) && $stable(i_res_axis)))
        else $error("stalled result changed");

endmodule

bind point_cloud_extreme_extent pcee_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_extent (o_res.longest_extent),
    .i_res_axis   (o_res.extent_axis)
);
